// ----- rtl/ace_pkg.sv -----
// Shared types, codes and decode functions for the accumulator CPU execute core.
// Used by every module under rtl; depends on nothing else.
package ace_pkg;

    // Input and result transactions
    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] address;
        logic [23:0] data;
    } t_ace_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] next_pc;
        logic [23:0] acc_value;
    } t_ace_out;

    // Instruction word layout
    typedef struct packed {
        logic [11:0] addr;
        logic [5:0]  op;
        logic [5:0]  mode;
    } t_ace_instr;

    // Transaction functions
    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_START = 2'd1;
    localparam logic [1:0] FN_EXEC  = 2'd2;
    localparam logic [1:0] FN_NONE  = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_HALT         = 3'd1;
    localparam logic [2:0] ST_UNIMPL_MODE  = 3'd2;
    localparam logic [2:0] ST_ILLEGAL_MODE = 3'd3;
    localparam logic [2:0] ST_UNIMPL_OP    = 3'd4;
    localparam logic [2:0] ST_UNDEF_OP     = 3'd5;
    localparam logic [2:0] ST_NOT_RUNNING  = 3'd6;

    // Opcodes
    localparam logic [5:0] OP_HALT = 6'd0;
    localparam logic [5:0] OP_LD   = 6'd1;
    localparam logic [5:0] OP_ADD  = 6'd2;
    localparam logic [5:0] OP_J    = 6'd3;
    localparam logic [5:0] OP_NOP  = 6'd4;
    localparam logic [5:0] OP_ST   = 6'd5;
    localparam logic [5:0] OP_SUB  = 6'd6;
    localparam logic [5:0] OP_JZ   = 6'd7;
    localparam logic [5:0] OP_EM   = 6'd9;
    localparam logic [5:0] OP_CLR  = 6'd10;
    localparam logic [5:0] OP_JN   = 6'd11;
    localparam logic [5:0] OP_COM  = 6'd14;
    localparam logic [5:0] OP_JP   = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd18;
    localparam logic [5:0] OP_OR   = 6'd22;
    localparam logic [5:0] OP_XOR  = 6'd26;
    localparam logic [5:0] OP_XLD  = 6'd33;
    localparam logic [5:0] OP_XADD = 6'd34;
    localparam logic [5:0] OP_XST  = 6'd37;
    localparam logic [5:0] OP_XSUB = 6'd38;
    localparam logic [5:0] OP_XEM  = 6'd41;
    localparam logic [5:0] OP_XCLR = 6'd42;

    // Addressing modes
    localparam logic [5:0] MODE_DIRECT   = 6'd0;
    localparam logic [5:0] MODE_IMM      = 6'd1;
    localparam logic [5:0] MODE_INDEXED  = 6'd2;
    localparam logic [5:0] MODE_INDIRECT = 6'd4;
    localparam logic [5:0] MODE_IDX_IND  = 6'd6;

    // Microprogram steps
    typedef enum logic [3:0] {
        U_CLEAR   = 4'd0,
        U_IDLE    = 4'd1,
        U_WRITE   = 4'd2,
        U_START   = 4'd3,
        U_NOTRUN  = 4'd4,
        U_IGNORE  = 4'd5,
        U_DECODE  = 4'd6,
        U_ALU     = 4'd7,
        U_STORE   = 4'd8,
        U_SWAP    = 4'd9,
        U_JUMP    = 4'd10,
        U_CLRAC   = 4'd11,
        U_COMAC   = 4'd12,
        U_NOP     = 4'd13,
        U_STOP    = 4'd14,
        U_EMIT    = 4'd15
    } t_ace_upc;

    // Instruction classes seen by the dispatch step
    typedef enum logic [2:0] {
        CLS_STOP, CLS_ALU, CLS_ST, CLS_EM, CLS_JMP, CLS_CLR, CLS_COM, CLS_NOP
    } t_ace_cls;

    typedef enum logic [2:0] { A_PC, A_IN, A_IRD, A_EA, A_CLR } t_ace_asel;
    typedef enum logic [1:0] { W_ZERO, W_IN, W_AC } t_ace_wsel;
    typedef enum logic [2:0] { AC_KEEP, AC_ALU, AC_ZERO, AC_COM, AC_MEM } t_ace_acsel;
    typedef enum logic [1:0] { PC_KEEP, PC_IN, PC_INC, PC_BR } t_ace_pcsel;
    typedef enum logic [1:0] { RUN_KEEP, RUN_SET, RUN_CLR } t_ace_runsel;
    typedef enum logic [1:0] { STS_KEEP, STS_OK, STS_IDLE, STS_DEC } t_ace_stsel;
    typedef enum logic [2:0] { SQ_JUMP, SQ_CLR, SQ_FUNC, SQ_OP, SQ_EMIT } t_ace_sqsel;

    // One control word of the microprogram
    typedef struct packed {
        logic        in_ready;
        logic        mem_rd;
        logic        mem_wr;
        t_ace_asel   asel;
        t_ace_wsel   wsel;
        t_ace_acsel  acsel;
        t_ace_pcsel  pcsel;
        t_ace_runsel runsel;
        t_ace_stsel  stsel;
        logic        ir_ld;
        logic        clr_inc;
        logic        emit;
        t_ace_sqsel  sq;
        t_ace_upc    target;
    } t_ace_ctl;

    // Conditions the datapath reports to the sequencer
    typedef struct packed {
        logic     clr_last;
        logic     running;
        logic     out_free;
        t_ace_cls cls;
    } t_ace_flags;

    typedef struct packed {
        t_ace_cls   cls;
        logic [2:0] status;
    } t_ace_dec;

    function automatic logic [2:0] f_mode_chk(input logic [5:0] mode, input logic imm_ok);
        logic [2:0] s;
        if (mode == MODE_DIRECT) begin
            s = ST_OK;
        end else if (mode == MODE_IMM) begin
            s = imm_ok ? ST_OK : ST_ILLEGAL_MODE;
        end else if (mode == MODE_INDEXED || mode == MODE_INDIRECT || mode == MODE_IDX_IND) begin
            s = ST_UNIMPL_MODE;
        end else begin
            s = ST_ILLEGAL_MODE;
        end
        return s;
    endfunction

    // Classify an instruction; a stop carries its status code
    function automatic t_ace_dec f_decode(input logic [5:0] op, input logic [5:0] mode);
        t_ace_dec   d;
        logic [2:0] ms;
        d.cls    = CLS_STOP;
        d.status = ST_OK;
        ms       = ST_OK;
        unique case (op)
            OP_HALT: d.status = ST_HALT;
            OP_NOP:  d.cls = CLS_NOP;
            OP_CLR:  d.cls = CLS_CLR;
            OP_COM:  d.cls = CLS_COM;
            OP_LD, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
                ms = f_mode_chk(mode, 1'b1);
                if (ms == ST_OK) d.cls = CLS_ALU;
                else d.status = ms;
            end
            OP_ST: begin
                ms = f_mode_chk(mode, 1'b0);
                if (ms == ST_OK) d.cls = CLS_ST;
                else d.status = ms;
            end
            OP_EM: begin
                ms = f_mode_chk(mode, 1'b0);
                if (ms == ST_OK) d.cls = CLS_EM;
                else d.status = ms;
            end
            OP_J, OP_JZ, OP_JN, OP_JP: begin
                ms = f_mode_chk(mode, 1'b0);
                if (ms == ST_OK) d.cls = CLS_JMP;
                else d.status = ms;
            end
            OP_XLD, OP_XADD, OP_XST, OP_XSUB, OP_XEM, OP_XCLR: d.status = ST_UNIMPL_OP;
            default: d.status = ST_UNDEF_OP;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/accumulator_cpu_execute_core.sv -----
// After reset the core zeroes its MEM_DEPTH-word memory, one word a cycle, with ready low.
// A write, start, ignored or not-running transaction passes through its own step and then
// the result step; an executed instruction passes through operand read, execute and result
// steps, its word fetched from the single-port memory in the accepting cycle. The result step
// waits while the result register is full. One transaction is in flight at a time; the next
// is accepted the cycle after the result register takes the current one.
module accumulator_cpu_execute_core #(
    parameter int MEM_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ace_pkg::t_ace_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ace_pkg::t_ace_out o_out
);
    import ace_pkg::*;

    t_ace_ctl   ctl;
    t_ace_flags flags;

    ace_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in.func),
        .i_flags    (flags),
        .o_ctl      (ctl)
    );

    ace_dpath #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    assign o_in_ready = ctl.in_ready;

endmodule

// ----- rtl/ace_seq.sv -----
// Microprogram sequencer: step counter, control store and dispatch logic.
// Depends on ace_pkg for the control word, flags and step encoding.
module ace_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_func,
    input  ace_pkg::t_ace_flags i_flags,
    output ace_pkg::t_ace_ctl   o_ctl
);
    import ace_pkg::*;

    t_ace_upc r_upc;
    t_ace_upc n_upc;

    // Control store, one word per step
    function automatic t_ace_ctl f_ucode(input t_ace_upc upc);
        t_ace_ctl c;
        c        = '0;
        c.sq     = SQ_JUMP;
        c.target = U_EMIT;
        unique case (upc)
            U_CLEAR: begin
                c.mem_wr  = 1'b1;
                c.asel    = A_CLR;
                c.wsel    = W_ZERO;
                c.clr_inc = 1'b1;
                c.sq      = SQ_CLR;
                c.target  = U_CLEAR;
            end
            U_IDLE: begin
                c.in_ready = 1'b1;
                c.mem_rd   = 1'b1;
                c.asel     = A_PC;
                c.sq       = SQ_FUNC;
            end
            U_WRITE: begin
                c.mem_wr = 1'b1;
                c.asel   = A_IN;
                c.wsel   = W_IN;
                c.stsel  = STS_OK;
            end
            U_START: begin
                c.pcsel  = PC_IN;
                c.runsel = RUN_SET;
                c.stsel  = STS_OK;
            end
            U_NOTRUN: c.stsel = STS_IDLE;
            U_IGNORE: c.stsel = STS_OK;
            U_DECODE: begin
                c.ir_ld  = 1'b1;
                c.mem_rd = 1'b1;
                c.asel   = A_IRD;
                c.sq     = SQ_OP;
            end
            U_ALU: begin
                c.acsel = AC_ALU;
                c.pcsel = PC_INC;
                c.stsel = STS_OK;
            end
            U_STORE: begin
                c.mem_wr = 1'b1;
                c.asel   = A_EA;
                c.wsel   = W_AC;
                c.pcsel  = PC_INC;
                c.stsel  = STS_OK;
            end
            U_SWAP: begin
                c.mem_wr = 1'b1;
                c.asel   = A_EA;
                c.wsel   = W_AC;
                c.acsel  = AC_MEM;
                c.pcsel  = PC_INC;
                c.stsel  = STS_OK;
            end
            U_JUMP: begin
                c.pcsel = PC_BR;
                c.stsel = STS_OK;
            end
            U_CLRAC: begin
                c.acsel = AC_ZERO;
                c.pcsel = PC_INC;
                c.stsel = STS_OK;
            end
            U_COMAC: begin
                c.acsel = AC_COM;
                c.pcsel = PC_INC;
                c.stsel = STS_OK;
            end
            U_NOP: begin
                c.pcsel = PC_INC;
                c.stsel = STS_OK;
            end
            U_STOP: begin
                c.runsel = RUN_CLR;
                c.stsel  = STS_DEC;
            end
            U_EMIT: begin
                c.emit   = 1'b1;
                c.sq     = SQ_EMIT;
                c.target = U_IDLE;
            end
            default: c.target = U_IDLE;
        endcase
        return c;
    endfunction

    always_comb begin
        o_ctl = f_ucode(r_upc);
    end

    always_comb begin
        n_upc = r_upc;
        unique case (o_ctl.sq)
            SQ_JUMP: n_upc = o_ctl.target;
            SQ_CLR:  n_upc = i_flags.clr_last ? U_IDLE : o_ctl.target;
            SQ_FUNC: begin
                if (i_in_valid) begin
                    unique case (i_func)
                        FN_WRITE: n_upc = U_WRITE;
                        FN_START: n_upc = U_START;
                        FN_EXEC:  n_upc = i_flags.running ? U_DECODE : U_NOTRUN;
                        FN_NONE:  n_upc = U_IGNORE;
                        default:  n_upc = U_IGNORE;
                    endcase
                end
            end
            SQ_OP: begin
                unique case (i_flags.cls)
                    CLS_ALU:  n_upc = U_ALU;
                    CLS_ST:   n_upc = U_STORE;
                    CLS_EM:   n_upc = U_SWAP;
                    CLS_JMP:  n_upc = U_JUMP;
                    CLS_CLR:  n_upc = U_CLRAC;
                    CLS_COM:  n_upc = U_COMAC;
                    CLS_NOP:  n_upc = U_NOP;
                    CLS_STOP: n_upc = U_STOP;
                    default:  n_upc = U_STOP;
                endcase
            end
            // hold until the result register can take the transaction
            SQ_EMIT: if (i_flags.out_free) n_upc = o_ctl.target;
            default: n_upc = o_ctl.target;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_CLEAR;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ----- rtl/ace_dpath.sv -----
// Datapath: single-port word memory, accumulator, program counter, IR and result register.
// Depends on ace_pkg; driven by the control words of ace_seq.
module ace_dpath #(
    parameter int MEM_DEPTH = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ace_pkg::t_ace_ctl   i_ctl,
    input  logic                i_in_valid,
    input  ace_pkg::t_ace_in    i_in,
    output ace_pkg::t_ace_flags o_flags,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ace_pkg::t_ace_out   o_out
);
    import ace_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    logic [23:0] r_mem [MEM_DEPTH];
    logic [23:0] r_rdata;
    t_ace_instr  r_ir;
    t_ace_in     r_in;
    logic [23:0] r_ac;
    logic [11:0] r_pc;
    logic        r_run;
    logic [2:0]  r_status;
    logic [AW-1:0] r_clr;
    logic        r_out_valid;
    t_ace_out    r_out;

    logic [23:0] n_ac;
    logic [11:0] n_pc;
    logic        n_run;
    logic [2:0]  n_status;

    logic [AW-1:0] mem_addr;
    logic [23:0]   mem_wdata;
    t_ace_instr    rd_instr;
    t_ace_dec      rd_dec;
    t_ace_dec      ir_dec;
    logic [23:0]   opnd;
    logic [23:0]   alu_res;
    logic [11:0]   pc_inc;
    logic          br_take;
    logic          out_free;

    // Reduce a 12-bit address modulo the memory depth (for depths of 16 or more) by shifted compare-subtract
    function automatic logic [AW-1:0] f_idx(input logic [11:0] a);
        logic [12:0] r;
        r = {1'b0, a};
        for (int k = 7; k >= 0; k--) begin
            if ((MEM_DEPTH << k) <= 4095) begin
                if (r >= 13'(MEM_DEPTH << k)) r = r - 13'(MEM_DEPTH << k);
            end
        end
        return r[AW-1:0];
    endfunction

    assign rd_instr = t_ace_instr'(r_rdata);
    assign rd_dec   = f_decode(rd_instr.op, rd_instr.mode);
    assign ir_dec   = f_decode(r_ir.op, r_ir.mode);
    assign out_free = !r_out_valid || i_out_ready;
    assign pc_inc   = r_pc + 12'd1;

    always_comb begin
        unique case (i_ctl.asel)
            A_PC:    mem_addr = f_idx(r_pc);
            A_IN:    mem_addr = f_idx(r_in.address);
            A_IRD:   mem_addr = f_idx(rd_instr.addr);
            A_EA:    mem_addr = f_idx(r_ir.addr);
            A_CLR:   mem_addr = r_clr;
            default: mem_addr = r_clr;
        endcase
    end

    always_comb begin
        unique case (i_ctl.wsel)
            W_ZERO:  mem_wdata = '0;
            W_IN:    mem_wdata = r_in.data;
            W_AC:    mem_wdata = r_ac;
            default: mem_wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mem_wr) r_mem[mem_addr] <= mem_wdata;
        if (i_ctl.mem_rd) r_rdata <= r_mem[mem_addr];
    end

    // Operand and ALU
    assign opnd = (r_ir.mode == MODE_IMM) ? {12'd0, r_ir.addr} : r_rdata;

    always_comb begin
        unique case (r_ir.op)
            OP_LD:   alu_res = opnd;
            OP_ADD:  alu_res = r_ac + opnd;
            OP_SUB:  alu_res = r_ac - opnd;
            OP_AND:  alu_res = r_ac & opnd;
            OP_OR:   alu_res = r_ac | opnd;
            OP_XOR:  alu_res = r_ac ^ opnd;
            default: alu_res = r_ac;
        endcase
    end

    always_comb begin
        unique case (r_ir.op)
            OP_J:    br_take = 1'b1;
            OP_JZ:   br_take = (r_ac == 24'd0);
            OP_JN:   br_take = r_ac[23];
            OP_JP:   br_take = (r_ac != 24'd0) && !r_ac[23];
            default: br_take = 1'b0;
        endcase
    end

    always_comb begin
        unique case (i_ctl.acsel)
            AC_KEEP: n_ac = r_ac;
            AC_ALU:  n_ac = alu_res;
            AC_ZERO: n_ac = '0;
            AC_COM:  n_ac = ~r_ac;
            AC_MEM:  n_ac = r_rdata;
            default: n_ac = r_ac;
        endcase
        unique case (i_ctl.pcsel)
            PC_KEEP: n_pc = r_pc;
            PC_IN:   n_pc = r_in.address;
            PC_INC:  n_pc = pc_inc;
            PC_BR:   n_pc = br_take ? r_ir.addr : pc_inc;
            default: n_pc = r_pc;
        endcase
        unique case (i_ctl.runsel)
            RUN_KEEP: n_run = r_run;
            RUN_SET:  n_run = 1'b1;
            RUN_CLR:  n_run = 1'b0;
            default:  n_run = r_run;
        endcase
        unique case (i_ctl.stsel)
            STS_KEEP: n_status = r_status;
            STS_OK:   n_status = ST_OK;
            STS_IDLE: n_status = ST_NOT_RUNNING;
            STS_DEC:  n_status = ir_dec.status;
            default:  n_status = r_status;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac        <= '0;
            r_pc        <= '0;
            r_run       <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ac  <= n_ac;
            r_pc  <= n_pc;
            r_run <= n_run;
            if (i_ctl.clr_inc) r_clr <= r_clr + 1'b1;
            if (i_ctl.emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (i_ctl.in_ready && i_in_valid) r_in <= i_in;
        if (i_ctl.ir_ld) r_ir <= rd_instr;
        if (i_ctl.emit && out_free) begin
            r_out.status    <= r_status;
            r_out.next_pc   <= r_pc;
            r_out.acc_value <= r_ac;
        end
    end

    always_comb begin
        o_flags.clr_last = (r_clr == AW'(MEM_DEPTH - 1));
        o_flags.running  = r_run;
        o_flags.out_free = out_free;
        o_flags.cls      = rd_dec.cls;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
